FILE: hdl/brm_pkg.sv
// Shared types, constants and a helper function for the banked ROM mapper.
`default_nettype none
package brm_pkg;

    localparam logic [15:0] TILT_CENTER   = 16'h81D0;
    localparam logic [3:0]  ENABLE_NIBBLE = 4'hA;
    localparam logic [7:0]  ENABLE_BYTE   = 8'h40;
    localparam logic [7:0]  RESET_KEY     = 8'h55;
    localparam logic [7:0]  CAPTURE_KEY   = 8'hAA;
    localparam logic [7:0]  OPEN_BYTE     = 8'hFF;
    localparam logic [7:0]  ZERO_BYTE     = 8'h00;
    localparam logic [7:0]  BANK_DEFAULT  = 8'h01;

    localparam logic       FUNC_READ  = 1'b0;
    localparam logic       FUNC_WRITE = 1'b1;

    localparam logic [3:0] SUB_TILT_RESET   = 4'd0;
    localparam logic [3:0] SUB_TILT_CAPTURE = 4'd1;
    localparam logic [3:0] SUB_TILT_X_LO    = 4'd2;
    localparam logic [3:0] SUB_TILT_X_HI    = 4'd3;
    localparam logic [3:0] SUB_TILT_Y_LO    = 4'd4;
    localparam logic [3:0] SUB_TILT_Y_HI    = 4'd5;
    localparam logic [3:0] SUB_ZERO         = 4'd6;
    localparam logic [3:0] SUB_ONES         = 4'd7;
    localparam logic [3:0] SUB_EEPROM       = 4'd8;

    localparam int ROM_ADDR_W = 22;

    typedef struct packed {
        logic               func;
        logic [15:0]        address;
        logic [7:0]         data;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic [7:0]         eeprom_byte;
    } t_item;

    typedef struct packed {
        logic [7:0]            read_data;
        logic                  rom_access;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic                  eeprom_write;
        logic                  eeprom_read;
    } t_result;

    function automatic logic [15:0] tilt_capture(input logic signed [15:0] axis);
        logic signed [16:0] v;
        v = $signed({1'b0, TILT_CENTER}) - $signed({{9{axis[15]}}, axis[15:8]});
        if (v[16]) begin
            tilt_capture = 16'h0000;
        end else begin
            tilt_capture = v[15:0];
        end
    endfunction

endpackage
`default_nettype wire

FILE: hdl/brm_decode.sv
// Access decode, mapper state and result formation for one bus transaction.
`default_nettype none
module brm_decode (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire brm_pkg::t_item    i_item,
    output brm_pkg::t_result       o_result
);
    import brm_pkg::*;

    logic [7:0]  r_rom_bank,  n_rom_bank;
    logic        r_en_first,  n_en_first;
    logic        r_en_second, n_en_second;
    logic [15:0] r_tilt_x,    n_tilt_x;
    logic [15:0] r_tilt_y,    n_tilt_y;

    logic [3:0] sub;
    logic       window;
    logic       enabled;

    assign sub     = i_item.address[7:4];
    assign window  = (i_item.address[15:12] == 4'hA);
    assign enabled = r_en_first && r_en_second;

    always_comb begin
        o_result    = '0;
        n_rom_bank  = r_rom_bank;
        n_en_first  = r_en_first;
        n_en_second = r_en_second;
        n_tilt_x    = r_tilt_x;
        n_tilt_y    = r_tilt_y;
        if (i_item.func == FUNC_READ) begin
            priority if (i_item.address[15:14] == 2'b00) begin
                o_result.rom_access  = 1'b1;
                o_result.rom_address = {8'h00, i_item.address[13:0]};
            end else if (i_item.address[15:14] == 2'b01) begin
                o_result.rom_access  = 1'b1;
                o_result.rom_address = {r_rom_bank, i_item.address[13:0]};
            end else if (window) begin
                o_result.read_data = OPEN_BYTE;
                if (enabled) begin
                    unique case (sub)
                        SUB_TILT_X_LO: o_result.read_data = r_tilt_x[7:0];
                        SUB_TILT_X_HI: o_result.read_data = r_tilt_x[15:8];
                        SUB_TILT_Y_LO: o_result.read_data = r_tilt_y[7:0];
                        SUB_TILT_Y_HI: o_result.read_data = r_tilt_y[15:8];
                        SUB_ZERO:      o_result.read_data = ZERO_BYTE;
                        SUB_EEPROM: begin
                            o_result.read_data   = i_item.eeprom_byte;
                            o_result.eeprom_read = 1'b1;
                        end
                        default:       o_result.read_data = OPEN_BYTE;
                    endcase
                end
            end else begin
                o_result.read_data = i_item.data;
            end
        end else begin
            if (i_item.address[15:13] == 3'b000) begin
                n_en_first = (i_item.data[3:0] == ENABLE_NIBBLE);
                if (!n_en_first) begin
                    n_en_second = 1'b0;
                end
            end else if (i_item.address[15:13] == 3'b001) begin
                n_rom_bank = (i_item.data == ZERO_BYTE) ? BANK_DEFAULT : i_item.data;
            end else if (i_item.address[15:13] == 3'b010) begin
                if (r_en_first) begin
                    n_en_second = (i_item.data == ENABLE_BYTE);
                end
            end else if (window && enabled) begin
                if (sub == SUB_TILT_RESET && i_item.data == RESET_KEY) begin
                    n_tilt_x = TILT_CENTER;
                    n_tilt_y = TILT_CENTER;
                end else if (sub == SUB_TILT_CAPTURE && i_item.data == CAPTURE_KEY) begin
                    n_tilt_x = tilt_capture(i_item.axis_x);
                    n_tilt_y = tilt_capture(i_item.axis_y);
                end else if (sub == SUB_EEPROM) begin
                    o_result.eeprom_write = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bank  <= BANK_DEFAULT;
            r_en_first  <= 1'b0;
            r_en_second <= 1'b0;
            r_tilt_x    <= TILT_CENTER;
            r_tilt_y    <= TILT_CENTER;
        end else if (i_advance) begin
            r_rom_bank  <= n_rom_bank;
            r_en_first  <= n_en_first;
            r_en_second <= n_en_second;
            r_tilt_x    <= n_tilt_x;
            r_tilt_y    <= n_tilt_y;
        end
    end

    a_bank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rom_bank != ZERO_BYTE)
        else $error("rom bank register holds zero");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_en_second |-> r_en_first)
        else $error("second enable stage set without first");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_advance) |-> $stable(r_tilt_x) && $stable(r_rom_bank))
        else $error("mapper state changed without a transaction");

    a_eeprom_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_result.eeprom_write && (o_result.eeprom_read || o_result.rom_access)))
        else $error("eeprom write flagged on a read");

endmodule
`default_nettype wire

FILE: hdl/banked_rom_mapper_with_tilt_latch_core.sv
// Top level: input register, decode stage and result register of the mapper.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | to core   | i_in_valid / o_in_ready    | func address data axis_x axis_y eeprom_byte
//  out     | from core | o_out_valid / i_out_ready  | read_data rom_access rom_address
//          |           |                            | eeprom_write eeprom_read
//
//  One transaction per cycle unless out stalls; each passes the input, then the result register.
//  Mapper state updates as the transaction moves from the input register to the result register.
//  A stall on the out side holds both registers; in stays ready while a slot frees this cycle.
//  Synchronous active-low reset restores bank 1, clears both enable stages, centers tilt.
`default_nettype none
module banked_rom_mapper_with_tilt_latch_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_func,
    input  wire logic [15:0]        i_address,
    input  wire logic [7:0]         i_data,
    input  wire logic signed [15:0] i_axis_x,
    input  wire logic signed [15:0] i_axis_y,
    input  wire logic [7:0]         i_eeprom_byte,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [7:0]              o_read_data,
    output logic                    o_rom_access,
    output logic [21:0]             o_rom_address,
    output logic                    o_eeprom_write,
    output logic                    o_eeprom_read
);
    import brm_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result result;
    logic    advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.func        <= i_func;
            r_item.address     <= i_address;
            r_item.data        <= i_data;
            r_item.axis_x      <= i_axis_x;
            r_item.axis_y      <= i_axis_y;
            r_item.eeprom_byte <= i_eeprom_byte;
        end
    end

    brm_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_item),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_result.read_data;
    assign o_rom_access   = r_result.rom_access;
    assign o_rom_address  = r_result.rom_address;
    assign o_eeprom_write = r_result.eeprom_write;
    assign o_eeprom_read  = r_result.eeprom_read;

endmodule
`default_nettype wire
